### sv/pre_pkg.sv
// Shared types, codes and sequencer states of the primitive root enumerator.
package pre_pkg;

  localparam int VW = 20;   // width of every value field
  localparam int DW = 11;   // trial divisor width: its square covers any 20-bit value
  localparam int CW = 5;    // step counter width of the serial units

  typedef logic [VW-1:0] val_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_TD,
    S_TD_W,
    S_PP,
    S_PP_W,
    S_PHI,
    S_PHI_W,
    S_FT,
    S_FT_W,
    S_FS,
    S_FS_W,
    S_GT,
    S_GT_W,
    S_ME,
    S_MR_W,
    S_MB,
    S_MB_W,
    S_GC,
    S_CLR,
    S_MKI,
    S_MK,
    S_MK_W,
    S_FR,
    S_FC,
    S_EMIT
  } st_t;

endpackage

### sv/pre_div.sv
// Restoring divider, one quotient bit per cycle.
module pre_div (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  pre_pkg::val_t dividend,
  input  pre_pkg::val_t divisor,
  output logic         done,
  output pre_pkg::val_t quot,
  output pre_pkg::val_t rem
);
  import pre_pkg::*;

  val_t          rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[VW-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(VW);
        rem_r <= '0;
        quo_r <= dividend;
        dvs_r <= divisor;
      end else if (run_r) begin
        // shift in the next dividend bit, subtract where it fits
        rem_r <= fits ? VW'(trial - {1'b0, dvs_r}) : VW'(trial);
        quo_r <= {quo_r[VW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

### sv/pre_mulmod.sv
// Serial modular multiplier: a * b mod m by double-and-add, one bit of b per cycle.
module pre_mulmod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  pre_pkg::val_t a,
  input  pre_pkg::val_t b,
  input  pre_pkg::val_t m,
  output logic          done,
  output pre_pkg::val_t prod
);
  import pre_pkg::*;

  val_t          acc_r, a_r, b_r;
  logic [CW-1:0] cnt_r;
  logic          run_r, done_r;
  logic [VW:0]   dbl, add;
  val_t          dbl_red;

  // operands stay below m, so one subtract after each step suffices
  assign dbl     = {acc_r, 1'b0};
  assign dbl_red = (dbl >= {1'b0, m}) ? VW'(dbl - {1'b0, m}) : VW'(dbl);
  assign add     = {1'b0, dbl_red} + (b_r[VW-1] ? {1'b0, a_r} : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(VW);
        acc_r <= '0;
        a_r   <= a;
        b_r   <= b;
      end else if (run_r) begin
        acc_r <= (add >= {1'b0, m}) ? VW'(add - {1'b0, m}) : VW'(add);
        b_r   <= {b_r[VW-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### sv/pre_bitmap.sv
// One-bit root map: single write port, registered read port.
module pre_bitmap #(
  parameter int unsigned DEPTH = 1048576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic                     wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic                     rdata
);
  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/primitive_root_enumerator.sv
// Primitive root enumerator top level: sequencer, shared divider and multiplier, root map.
//
//  channel  | ports                                           | handshake
//  ---------+-------------------------------------------------+---------------------------
//  input    | in_op, in_modulus, in_stride                    | start high, busy low
//  result   | out_root_count, out_root_value,                 | out_valid, one cycle,
//           | out_value_valid, out_last                       | cannot be held off
//
//  A start transaction runs the trial division (by each divisor up to the square root),
//  the generator tests (modular products, one or two per exponent bit), a clearing sweep
//  over the m positions of the root map, then a pass over the exponents 1..phi(m).
//  The serial divider and multiplier and the single map port pace these steps.
//  A fetch transaction scans map positions one at a time (registered read).
//  Reset is synchronous; the map holds no reset value and is cleared by each start
//  that finds a primitive root.
//  Every transaction gives exactly one result; busy drops in the cycle it is shown.
module primitive_root_enumerator #(
  parameter int unsigned MAX_MODULUS = 1048576,
  parameter int unsigned MAX_PRIMES  = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic          in_op,
  input  pre_pkg::val_t in_modulus,
  input  pre_pkg::val_t in_stride,
  output logic          out_valid,
  output pre_pkg::val_t out_root_count,
  output pre_pkg::val_t out_root_value,
  output logic          out_value_valid,
  output logic          out_last
);
  import pre_pkg::*;

  localparam int AW  = $clog2(MAX_MODULUS);
  localparam int PCW = $clog2(MAX_PRIMES + 1);
  localparam int PIW = $clog2(MAX_PRIMES);
  localparam logic [24:0] MAXM = 25'(MAX_MODULUS);

  st_t state_r, state_nxt;

  // query state
  logic           active_r, has_r;
  val_t           m_r, s_r, t_r, g_r, total_r, seen_r, pos_r, target_r;
  // factoring and testing workspace
  val_t           n_r, n0_r, p_r, tw_r, e_r, r_r, b_r, i_r, k_r;
  logic [DW-1:0]  d_r;
  logic [PCW-1:0] pc_r, j_r;
  val_t           q_r   [MAX_PRIMES];
  val_t           res_r [MAX_PRIMES];
  // result staging
  val_t           val_r;
  logic           vv_r, last_r;
  logic           out_valid_r, out_vv_r, out_last_r;
  val_t           out_count_r, out_value_r;

  // shared units
  logic div_start, div_done, mm_start, mm_done;
  val_t div_a, div_b, div_q, div_rem, mm_a, mm_b, mm_p;

  // map port
  logic          map_we, map_wdata, map_rdata;
  logic [AW-1:0] map_waddr, map_raddr;

  // decisions
  logic [21:0]   dsq;
  logic          td_stop, ft_stop, chk_bad, pc_full, jlast, pass, g_end, i_end;
  logic          fetch_ok, cop, fc_more, big;
  val_t          nn, qsel, seen_n;

  assign dsq     = 22'(d_r) * 22'(d_r);
  assign td_stop = dsq > 22'(n_r);
  assign ft_stop = dsq > 22'(tw_r);
  assign big     = {5'd0, m_r} >= MAXM;
  assign nn      = m_r[0] ? m_r : (m_r >> 1);
  assign chk_bad = !m_r[0] && (!nn[0] || nn < 20'd3);
  assign pc_full = pc_r >= PCW'(MAX_PRIMES);
  assign jlast   = j_r == pc_r;
  assign qsel    = q_r[PIW'(j_r - 1'b1)];
  assign pass    = (j_r == '0) ? (r_r == 20'd1) : (r_r != 20'd1);
  assign g_end   = ({1'b0, g_r} + 21'd1) >= {1'b0, m_r};
  assign i_end   = i_r == t_r;
  assign fetch_ok = active_r && has_r && (s_r != '0) &&
                    (({1'b0, seen_r} + {1'b0, s_r}) <= {1'b0, total_r});
  assign seen_n  = seen_r + VW'(map_rdata);
  assign fc_more = (({1'b0, pos_r} + 21'd1) < {1'b0, m_r}) && (seen_n < target_r);

  // exponent is coprime to phi when no listed prime leaves residue zero
  always_comb begin
    cop = 1'b1;
    for (int j = 0; j < MAX_PRIMES; j++) begin
      if ((PCW'(j) < pc_r) && (res_r[j] == '0)) cop = 1'b0;
    end
  end

  pre_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  pre_mulmod u_mm (
    .clk(clk), .rst_n(rst_n), .start(mm_start), .a(mm_a), .b(mm_b), .m(m_r),
    .done(mm_done), .prod(mm_p)
  );

  pre_bitmap #(.DEPTH(MAX_MODULUS)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_op == OP_START) state_nxt = S_CHK;
          else if (fetch_ok)     state_nxt = S_FR;
          else                   state_nxt = S_EMIT;
        end
      end
      S_CHK: begin
        if (big)                                   state_nxt = S_EMIT;
        else if (m_r == 20'd2 || m_r == 20'd4)     state_nxt = S_GT;
        else if (m_r < 20'd3 || chk_bad)           state_nxt = S_EMIT;
        else                                       state_nxt = S_TD;
      end
      S_TD:    state_nxt = td_stop ? S_PP : S_TD_W;
      S_TD_W:  if (div_done) state_nxt = (div_rem == '0) ? S_PP : S_TD;
      S_PP:    state_nxt = S_PP_W;
      S_PP_W: begin
        if (div_done) begin
          if (div_rem == '0)      state_nxt = S_PP;
          else if (n_r == 20'd1)  state_nxt = S_PHI;
          else                    state_nxt = S_EMIT;
        end
      end
      S_PHI:   state_nxt = S_PHI_W;
      S_PHI_W: if (div_done) state_nxt = S_FT;
      S_FT: begin
        if (!ft_stop)                      state_nxt = S_FT_W;
        else if (tw_r > 20'd1 && pc_full)  state_nxt = S_EMIT;
        else                               state_nxt = S_GT;
      end
      S_FT_W: begin
        if (div_done) begin
          if (div_rem != '0) state_nxt = S_FT;
          else if (pc_full)  state_nxt = S_EMIT;
          else               state_nxt = S_FS;
        end
      end
      S_FS:    state_nxt = S_FS_W;
      S_FS_W:  if (div_done) state_nxt = (div_rem == '0) ? S_FS : S_FT;
      S_GT:    state_nxt = (j_r == '0) ? S_ME : S_GT_W;
      S_GT_W:  if (div_done) state_nxt = S_ME;
      S_ME: begin
        if (e_r == '0)  state_nxt = S_GC;
        else if (e_r[0]) state_nxt = S_MR_W;
        else            state_nxt = S_MB;
      end
      S_MR_W:  if (mm_done) state_nxt = S_MB;
      S_MB:    state_nxt = S_MB_W;
      S_MB_W:  if (mm_done) state_nxt = S_ME;
      S_GC: begin
        if (!pass)      state_nxt = g_end ? S_EMIT : S_GT;
        else if (jlast) state_nxt = S_CLR;
        else            state_nxt = S_GT;
      end
      S_CLR:   if (i_r == m_r - 20'd1) state_nxt = S_MKI;
      S_MKI:   state_nxt = S_MK;
      S_MK:    state_nxt = i_end ? S_EMIT : S_MK_W;
      S_MK_W:  if (mm_done) state_nxt = S_MK;
      S_FR:    state_nxt = S_FC;
      S_FC:    state_nxt = fc_more ? S_FR : S_EMIT;
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit requests and map port
  always_comb begin
    div_start = 1'b0;
    div_a     = n_r;
    div_b     = VW'(d_r);
    mm_start  = 1'b0;
    mm_a      = k_r;
    mm_b      = g_r;
    map_we    = 1'b0;
    map_wdata = 1'b0;
    map_waddr = AW'(k_r);
    map_raddr = AW'(pos_r + 20'd1);
    case (state_r)
      S_TD:  div_start = !td_stop;
      S_PP: begin
        div_start = 1'b1;
        div_b     = p_r;
      end
      S_PHI: begin
        div_start = 1'b1;
        div_a     = n0_r;
        div_b     = p_r;
      end
      S_FT: begin
        div_start = !ft_stop;
        div_a     = tw_r;
      end
      S_FS: begin
        div_start = 1'b1;
        div_a     = tw_r;
      end
      S_GT: begin
        div_start = j_r != '0;
        div_a     = t_r;
        div_b     = qsel;
      end
      S_ME: begin
        mm_start = (e_r != '0) && e_r[0];
        mm_a     = r_r;
        mm_b     = b_r;
      end
      S_MB: begin
        mm_start = 1'b1;
        mm_a     = b_r;
        mm_b     = b_r;
      end
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = AW'(i_r);
      end
      S_MK: begin
        map_we    = cop;
        map_wdata = 1'b1;
        mm_start  = !i_end;
      end
      default: ;
    endcase
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      has_r       <= 1'b0;
      m_r         <= '0;
      s_r         <= '0;
      t_r         <= '0;
      pc_r        <= '0;
      g_r         <= '0;
      total_r     <= '0;
      seen_r      <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_EMIT;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            val_r  <= '0;
            vv_r   <= 1'b0;
            last_r <= 1'b0;
            if (in_op == OP_START) begin
              // drop the previous query entirely
              active_r <= 1'b1;
              has_r    <= 1'b0;
              m_r      <= in_modulus;
              s_r      <= in_stride;
              t_r      <= '0;
              pc_r     <= '0;
              g_r      <= '0;
              total_r  <= '0;
              seen_r   <= '0;
              pos_r    <= '0;
            end else begin
              target_r <= seen_r + s_r;
            end
          end
        end
        S_CHK: begin
          j_r <= '0;
          if (m_r == 20'd2) begin
            t_r  <= 20'd1;
            pc_r <= '0;
            g_r  <= 20'd1;
          end else if (m_r == 20'd4) begin
            t_r    <= 20'd2;
            q_r[0] <= 20'd2;
            pc_r   <= PCW'(1);
            g_r    <= 20'd1;
          end else begin
            n_r  <= nn;
            n0_r <= nn;
            d_r  <= DW'(2);
          end
        end
        S_TD: if (td_stop) p_r <= n_r;
        S_TD_W: begin
          if (div_done) begin
            if (div_rem == '0) p_r <= VW'(d_r);
            else               d_r <= d_r + 1'b1;
          end
        end
        S_PP_W: if (div_done && div_rem == '0) n_r <= div_q;
        S_PHI_W: begin
          if (div_done) begin
            t_r  <= VW'(div_q * (p_r - 20'd1));
            tw_r <= VW'(div_q * (p_r - 20'd1));
            d_r  <= DW'(2);
            pc_r <= '0;
          end
        end
        S_FT: begin
          if (ft_stop) begin
            j_r <= '0;
            g_r <= 20'd1;
            if (tw_r > 20'd1 && !pc_full) begin
              q_r[PIW'(pc_r)] <= tw_r;
              pc_r            <= pc_r + 1'b1;
            end
          end
        end
        S_FT_W: begin
          if (div_done) begin
            if (div_rem != '0) d_r <= d_r + 1'b1;
            else if (!pc_full) begin
              q_r[PIW'(pc_r)] <= VW'(d_r);
              pc_r            <= pc_r + 1'b1;
            end
          end
        end
        S_FS_W: begin
          if (div_done) begin
            if (div_rem == '0) tw_r <= div_q;
            else               d_r  <= d_r + 1'b1;
          end
        end
        S_GT: begin
          if (j_r == '0) begin
            e_r <= t_r;
            r_r <= 20'd1;
            b_r <= g_r;
          end
        end
        S_GT_W: begin
          if (div_done) begin
            e_r <= div_q;
            r_r <= 20'd1;
            b_r <= g_r;
          end
        end
        S_MR_W: if (mm_done) r_r <= mm_p;
        S_MB_W: begin
          if (mm_done) begin
            b_r <= mm_p;
            e_r <= e_r >> 1;
          end
        end
        S_GC: begin
          if (!pass) begin
            g_r <= g_r + 20'd1;
            j_r <= '0;
          end else if (jlast) begin
            i_r <= '0;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_CLR: i_r <= i_r + 20'd1;
        S_MKI: begin
          i_r <= 20'd1;
          k_r <= g_r;
          for (int j = 0; j < MAX_PRIMES; j++) res_r[j] <= 20'd1;
        end
        S_MK: begin
          total_r <= total_r + VW'(cop);
          if (i_end) begin
            has_r <= 1'b1;
          end else begin
            i_r <= i_r + 20'd1;
            for (int j = 0; j < MAX_PRIMES; j++) begin
              res_r[j] <= (res_r[j] + 20'd1 == q_r[j]) ? '0 : res_r[j] + 20'd1;
            end
          end
        end
        S_MK_W: if (mm_done) k_r <= mm_p;
        S_FR: pos_r <= pos_r + 20'd1;
        S_FC: begin
          seen_r <= seen_n;
          if (!fc_more && seen_n == target_r) begin
            val_r  <= pos_r;
            vv_r   <= 1'b1;
            last_r <= ({1'b0, seen_n} + {1'b0, s_r}) > {1'b0, total_r};
          end
        end
        S_EMIT: begin
          out_count_r <= total_r;
          out_value_r <= val_r;
          out_vv_r    <= vv_r;
          out_last_r  <= last_r;
        end
        default: ;
      endcase
    end
  end

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_root_count  = out_count_r;
  assign out_root_value  = out_value_r;
  assign out_value_valid = out_vv_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // a result is shown only once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while busy");

  // an accepted transaction always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transaction did not start");

  // a final flag comes only with a listed root
  a_last_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> out_value_valid) else $error("last without a root");

  // the prime list never overflows its store
  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PCW'(MAX_PRIMES)) else $error("prime count overflow");
`endif

endmodule

### bench/primitive_root_enumerator_tb.sv
// Self-checking testbench for the primitive root enumerator: directed and random queries.
`timescale 1ns / 1ps

module primitive_root_enumerator_tb;
  import pre_pkg::*;

  localparam int unsigned MOD_LIMIT = 1048576;
  localparam int unsigned PRIME_SLOTS = 8;

  typedef struct packed {
    val_t count;
    val_t value;
    logic value_valid;
    logic last;
  } root_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  val_t in_modulus = '0;
  val_t in_stride = '0;
  logic out_valid;
  val_t out_root_count;
  val_t out_root_value;
  logic out_value_valid;
  logic out_last;

  primitive_root_enumerator u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_modulus(in_modulus),
    .in_stride(in_stride),
    .out_valid(out_valid),
    .out_root_count(out_root_count),
    .out_root_value(out_root_value),
    .out_value_valid(out_value_valid),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  // Mirror of the query state held by the block.
  bit          mirror_active;
  int unsigned mirror_modulus;
  int unsigned mirror_stride;
  int unsigned mirror_totient;
  int unsigned mirror_primes[$];
  bit          mirror_has_root;
  int unsigned mirror_scan;
  int unsigned mirror_seen;
  int unsigned mirror_total;
  bit          mirror_map[];

  root_reply_t pending_replies[$];
  int          error_count = 0;
  int          burst_left = 0;

  function automatic int unsigned pow_mod(longint unsigned b, int unsigned e, int unsigned m);
    longint unsigned r;
    r = 1 % m;
    b = b % m;
    while (e != 0) begin
      if (e[0]) r = r * b % m;
      b = b * b % m;
      e = e >> 1;
    end
    return r;
  endfunction

  // True when n (above one) is a power of a single prime.
  function automatic bit single_prime_power(int unsigned n);
    int unsigned p;
    p = n;
    for (int unsigned d = 2; longint'(d) * d <= n; d++) begin
      if (n % d == 0) begin
        p = d;
        break;
      end
    end
    while (n % p == 0) n = n / p;
    return n == 1;
  endfunction

  function automatic bit has_primitive_root(int unsigned m);
    if (m == 2 || m == 4) return 1'b1;
    if (m < 3) return 1'b0;
    if (!m[0]) begin
      m = m >> 1;
      if (!m[0] || m < 3) return 1'b0;
    end
    return single_prime_power(m);
  endfunction

  function automatic int unsigned totient_of(int unsigned n);
    int unsigned r;
    r = n;
    for (int unsigned d = 2; longint'(d) * d <= n; d++) begin
      if (n % d == 0) begin
        r = r / d * (d - 1);
        while (n % d == 0) n = n / d;
      end
    end
    if (n > 1) r = r / n * (n - 1);
    return r;
  endfunction

  // Distinct primes of n into mirror_primes; zero when they overflow the slots.
  function automatic bit split_totient(int unsigned n);
    mirror_primes.delete();
    for (int unsigned d = 2; longint'(d) * d <= n; d++) begin
      if (n % d == 0) begin
        if (mirror_primes.size() >= PRIME_SLOTS) return 1'b0;
        mirror_primes.push_back(d);
        while (n % d == 0) n = n / d;
      end
    end
    if (n > 1) begin
      if (mirror_primes.size() >= PRIME_SLOTS) return 1'b0;
      mirror_primes.push_back(n);
    end
    return 1'b1;
  endfunction

  function automatic bit generates_group(int unsigned g, int unsigned m);
    if (pow_mod(g, mirror_totient, m) != 1 % m) return 1'b0;
    foreach (mirror_primes[i])
      if (pow_mod(g, mirror_totient / mirror_primes[i], m) == 1 % m) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void open_query(int unsigned m, int unsigned s);
    int unsigned g;
    longint unsigned k;
    bit coprime;
    mirror_active = 1'b1;
    mirror_modulus = m;
    mirror_stride = s;
    mirror_totient = 0;
    mirror_primes.delete();
    mirror_has_root = 1'b0;
    mirror_scan = 0;
    mirror_seen = 0;
    mirror_total = 0;
    if (m >= MOD_LIMIT || !has_primitive_root(m)) return;
    mirror_totient = totient_of(m);
    if (!split_totient(mirror_totient)) return;
    for (g = 1; g < m; g++)
      if (generates_group(g, m)) break;
    if (g >= m) return;
    mirror_map = new[m];
    k = g;
    for (int unsigned i = 1; i <= mirror_totient; i++) begin
      coprime = 1'b1;
      foreach (mirror_primes[j])
        if (i % mirror_primes[j] == 0) coprime = 1'b0;
      if (coprime) begin
        mirror_map[k] = 1'b1;
        mirror_total++;
      end
      k = k * g % m;
    end
    mirror_has_root = 1'b1;
  endfunction

  function automatic root_reply_t predict_reply(logic op, int unsigned m, int unsigned s);
    root_reply_t r;
    int unsigned target;
    int unsigned pos;
    r = '0;
    if (op == OP_START) begin
      open_query(m, s);
    end else if (mirror_active && mirror_has_root && mirror_stride != 0 &&
                 longint'(mirror_seen) + mirror_stride <= mirror_total) begin
      target = mirror_seen + mirror_stride;
      pos = mirror_scan;
      while (pos + 1 < mirror_modulus && mirror_seen < target) begin
        pos++;
        if (mirror_map[pos]) mirror_seen++;
      end
      mirror_scan = pos;
      if (mirror_seen == target) begin
        r.value = val_t'(pos);
        r.value_valid = 1'b1;
        r.last = (longint'(mirror_seen) + mirror_stride > mirror_total);
      end
    end
    r.count = val_t'(mirror_total);
    return r;
  endfunction

  task automatic report(string field, longint unsigned got, longint unsigned want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
    error_count++;
  endtask

  // Hold start and the fields until the block takes the transaction, then predict it.
  // Return at the accepting edge with start still high.
  task automatic send_item(logic op, int unsigned m, int unsigned s);
    root_reply_t r;
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1'b1;
    in_op <= op;
    in_modulus <= val_t'(m);
    in_stride <= val_t'(s);
    // busy only moves at a rising edge, so the falling edge gives a clean look at it
    do @(negedge clk); while (busy);
    @(posedge clk);
    r = predict_reply(op, m, s);
    pending_replies.push_back(r);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Compare every result with the oldest expectation.
  always @(posedge clk) begin
    root_reply_t want;
    if (rst_n && out_valid) begin
      if (pending_replies.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_root_count !== want.count) report("root_count", out_root_count, want.count);
        if (out_root_value !== want.value) report("root_value", out_root_value, want.value);
        if (out_value_valid !== want.value_valid)
          report("value_valid", out_value_valid, want.value_valid);
        if (out_last !== want.last) report("last", out_last, want.last);
      end
    end
  end

  // Fetches before any query and a few border moduli.
  task automatic test_border_cases();
    send_item(OP_FETCH, 20'hFFFFF, 20'hFFFFF);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 0, 1);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 1, 1);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 2, 1);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 4, 1);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 20'hFFFFF, 20'hFFFFF);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 1048572, 1);
    send_item(OP_START, 7, 0);
    send_item(OP_FETCH, 0, 0);
  endtask

  // Full listings, a stride beyond the count and a stride that leaves a tail.
  task automatic test_listing();
    send_item(OP_START, 7, 1);
    repeat (3) send_item(OP_FETCH, 0, 0);
    drain_replies();
    send_item(OP_START, 18, 2);
    repeat (2) send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 11, 20'hFFFFF);
    send_item(OP_FETCH, 0, 0);
    send_item(OP_START, 50, 3);
    repeat (4) send_item(OP_FETCH, 0, 0);
  endtask

  function automatic int unsigned pick_odd_prime(int unsigned hi);
    int unsigned p;
    forever begin
      p = $urandom_range(3, hi) | 1;
      if (single_prime_power(p) && totient_of(p) == p - 1) return p;
    end
  endfunction

  function automatic int unsigned pick_modulus();
    int unsigned p;
    case ($urandom_range(0, 5))
      0: return pick_odd_prime(1000);
      1: begin
        p = pick_odd_prime(31);
        return (p * p * p < 1100) ? p * p * p : p * p;
      end
      2: return 2 * pick_odd_prime(500);
      3: return 2 * pick_odd_prime(31) ** 2;
      4: return $urandom_range(2, 4);
      default: return $urandom_range(0, 1100);
    endcase
  endfunction

  // Mostly whole queries with their fetches; now and then stray fetches.
  task automatic test_random_queries();
    int sent;
    int unsigned s;
    int unsigned fetches;
    sent = 0;
    while (sent < 70) begin
      case ($urandom_range(0, 9))
        0: s = 0;
        1: s = $urandom_range(1, 1048575);
        2: s = 1;
        default: s = $urandom_range(1, 8);
      endcase
      send_item(OP_START, pick_modulus(), s);
      fetches = (s == 0 || mirror_total == 0) ? 1 : mirror_total / s + 1;
      if (fetches > 16) fetches = $urandom_range(4, 16);
      repeat (fetches)
        send_item(OP_FETCH, $urandom_range(0, 1048575), $urandom_range(0, 1048575));
      sent += fetches + 1;
      if ($urandom_range(0, 7) == 0) drain_replies();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_border_cases();
    drain_replies();
    test_listing();
    test_random_queries();
    drain_replies();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("primitive_root_enumerator regression: pass");
    end else begin
      $display("primitive_root_enumerator regression: fail");
    end
    $finish;
  end

  // Cap the run well above the slowest correct run.
  initial begin
    #400ms;
    $display("primitive_root_enumerator regression: fail");
    $finish;
  end

endmodule
